// ===== hw/rtl/bmo_pkg.sv =====
`default_nettype none
package bmo_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int LINES      = 4;
  localparam int WIN_N      = 5;
  localparam int KERN_HALF  = 2;
  localparam int MIN_SIZE   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPERATION    = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic                  OP_DILATE      = 1'b0;
  localparam logic                  OP_ERODE       = 1'b1;
  localparam logic [PIX_W-1:0]      PIX_SET        = 8'd255;
  localparam logic [PIX_W-1:0]      PIX_CLEAR      = 8'd0;
  localparam logic [PIX_W-1:0]      THRESHOLD_RST  = 8'd128;
  localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RST = 11'd512;

endpackage
`default_nettype wire

// ===== hw/rtl/bmo_line_buf.sv =====
`default_nettype none
module bmo_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  output logic      [DW-1:0] rd_data,
  output logic               clr_busy
);
  import bmo_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] clr_addr_r;
  logic          clr_busy_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;

  // sweep zeros through the store after reset
  always_comb begin
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = wr_en;
      waddr = wr_addr;
      wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == rd_addr)) begin
      rd_data_r <= wdata;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bmo_div.sv =====
`default_nettype none
module bmo_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 11,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic      [DEN_W-1:0] rem,
  output logic                  busy,
  output logic                  done
);
  import bmo_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign busy = (cnt_r != '0) || done_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bmo_window.sv =====
`default_nettype none
module bmo_window #(
  parameter int NW  = 20,
  parameter int CW  = 10,
  parameter int WW1 = 11,
  parameter int HW1 = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift_en,
  input  wire logic [bmo_pkg::WIN_N-1:0] col_in,
  input  wire logic [NW-1:0]             orow,
  input  wire logic [CW-1:0]             ocol,
  input  wire logic [WW1-1:0]            width,
  input  wire logic [HW1-1:0]            height,
  input  wire logic                      operation,
  output logic                           hit
);
  import bmo_pkg::*;

  localparam int WIN_BITS = WIN_N * WIN_N;

  logic [WIN_BITS-1:0] win_r;
  logic [WIN_BITS-1:0] win_nxt;
  logic [WIN_N-1:0]    row_ok;
  logic [WIN_N-1:0]    col_ok;
  logic                any_set;
  logic                all_set;
  logic                b;
  logic                corner;

  always_comb begin
    for (int r = 0; r < WIN_N; r++) begin
      win_nxt[r*WIN_N +: WIN_N] = {win_r[r*WIN_N +: WIN_N-1], col_in[r]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

  // row r covers image line orow + r - 2, column c covers ocol + 2 - c
  always_comb begin
    for (int r = 0; r < WIN_N; r++) begin
      row_ok[r] = (32'(orow) + 32'(r) >= 32'(KERN_HALF)) &&
                  (32'(orow) + 32'(r) < 32'(height) + 32'(KERN_HALF));
    end
    for (int c = 0; c < WIN_N; c++) begin
      col_ok[c] = (32'(ocol) + 32'(KERN_HALF) >= 32'(c)) &&
                  (32'(ocol) + 32'(KERN_HALF) < 32'(width) + 32'(c));
    end
  end

  always_comb begin
    any_set = 1'b0;
    all_set = 1'b1;
    for (int r = 0; r < WIN_N; r++) begin
      for (int c = 0; c < WIN_N; c++) begin
        corner = ((r == 0) || (r == WIN_N - 1)) && ((c == 0) || (c == WIN_N - 1));
        b      = win_nxt[r*WIN_N + c] && row_ok[r] && col_ok[c];
        if (!corner) begin
          any_set = any_set | b;
          all_set = all_set & b;
        end
      end
    end
    hit = (operation == OP_ERODE) ? all_set : any_set;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/binary_morphology_octagon_stream_top.sv =====
`default_nettype none
// Binary dilation / erosion with a 21-point octagon (5x5 without corners) on a
// raster pixel stream. Each grey pixel is thresholded, four line buffers feed a
// 5x5 window, and the result (255 or 0) leaves two lines and two pixels behind
// its input; send drain transfers (in_tuser high) after the last pixel to flush
// the tail of the frame, with out_tlast on the final result. One transfer is
// taken per clock while in_tready is high; the line store is one read and one
// write per cycle, read registered from the next column address. in_tready
// stays low after reset while the line store is cleared, and after a
// frame_width write while a serial divider recomputes the output position.
module binary_morphology_octagon_stream_top #(
  parameter int MAX_WIDTH  = bmo_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmo_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: [7:0] gray_level
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [bmo_pkg::PIX_W-1:0]      in_tdata,
  // in_tuser: [0] drain
  input  wire logic                           in_tuser,
  // out_tdata: [7:0] out_pixel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [bmo_pkg::PIX_W-1:0]      out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [bmo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmo_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bmo_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW1   = $clog2(MAX_WIDTH + 1);
  localparam int HW1   = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 4) + 1;
  localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DCNTW = $clog2(NW + 1);

  logic                  op_r;
  logic [PIX_W-1:0]      thr_r;
  logic [CFG_DATA_W-1:0] fw_r;
  logic [CFG_DATA_W-1:0] fh_r;
  logic                  div_pend_r;

  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [RW-1:0]  in_row_r, in_row_nxt;
  logic [NW-1:0]  out_cnt_r, out_cnt_nxt;
  logic [NW-1:0]  orow_r, orow_nxt;
  logic [CW-1:0]  ocol_r, ocol_nxt;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;

  logic [WW1-1:0]   w_eff;
  logic [HW1-1:0]   h_eff;
  logic             take, step, in_image, px_bit, pos_ge_lag, emit, is_last, frame_end;
  logic [LINES-1:0] lb_rd;
  logic             lb_busy;
  logic             hit;
  logic [NW-1:0]    div_quo;
  logic [WW1-1:0]   div_rem;
  logic             div_busy, div_done;

  always_comb begin
    if (32'(fw_r) < 32'(MIN_SIZE)) begin
      w_eff = WW1'(MIN_SIZE);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW1'(MAX_WIDTH);
    end else begin
      w_eff = WW1'(fw_r);
    end
    if (32'(fh_r) < 32'(MIN_SIZE)) begin
      h_eff = HW1'(MIN_SIZE);
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW1'(MAX_HEIGHT);
    end else begin
      h_eff = HW1'(fh_r);
    end
  end

  assign in_tready = !lb_busy && !div_pend_r && !div_busy && (!out_valid_r || out_tready);
  assign take      = in_tvalid && in_tready;
  assign in_image  = 32'(in_row_r) < 32'(h_eff);
  assign step      = take && !(in_image && in_tuser);
  assign px_bit    = in_image && (in_tdata >= thr_r);

  always_comb begin
    pos_ge_lag = (32'(in_row_r) >= 32'd3) ||
                 ((32'(in_row_r) == 32'd2) && (32'(in_col_r) >= 32'd2)) ||
                 ((32'(in_row_r) == 32'd1) && (32'(in_col_r) >= 32'(w_eff) + 32'd2)) ||
                 ((32'(in_row_r) == 32'd0) &&
                  (32'(in_col_r) >= 32'd2 * 32'(w_eff) + 32'd2));
    emit    = step && pos_ge_lag && (32'(orow_r) < 32'(h_eff));
    is_last = (32'(orow_r) + 32'd1 == 32'(h_eff)) && (32'(ocol_r) + 32'd1 == 32'(w_eff));
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_cnt_nxt = out_cnt_r;
    orow_nxt    = orow_r;
    ocol_nxt    = ocol_r;
    frame_end   = 1'b0;
    if (step) begin
      if (emit) begin
        out_cnt_nxt = out_cnt_r + 1'b1;
        if (32'(ocol_r) + 32'd1 >= 32'(w_eff)) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 1'b1;
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
      if (32'(in_col_r) + 32'd1 >= 32'(w_eff)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      frame_end = 32'(orow_nxt) >= 32'(h_eff);
      if (frame_end) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_cnt_nxt = '0;
        orow_nxt    = '0;
        ocol_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= OP_DILATE;
      thr_r      <= THRESHOLD_RST;
      fw_r       <= FRAME_SIZE_RST;
      fh_r       <= FRAME_SIZE_RST;
      div_pend_r <= 1'b0;
    end else begin
      div_pend_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_OPERATION:    op_r  <= cfg_wdata[0];
          REG_THRESHOLD:    thr_r <= cfg_wdata[PIX_W-1:0];
          REG_FRAME_WIDTH: begin
            fw_r       <= cfg_wdata;
            div_pend_r <= 1'b1;
          end
          REG_FRAME_HEIGHT: fh_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_cnt_r <= '0;
      orow_r    <= '0;
      ocol_r    <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_cnt_r <= out_cnt_nxt;
      if (div_done) begin
        orow_r <= div_quo;
        ocol_r <= CW'(div_rem);
      end else begin
        orow_r <= orow_nxt;
        ocol_r <= ocol_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r  <= hit ? PIX_SET : PIX_CLEAR;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  bmo_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (LINES)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (in_col_nxt),
    .wr_en    (step),
    .wr_addr  (in_col_r),
    .wr_data  ({px_bit, lb_rd[LINES-1:1]}),
    .rd_data  (lb_rd),
    .clr_busy (lb_busy)
  );

  bmo_window #(
    .NW  (NW),
    .CW  (CW),
    .WW1 (WW1),
    .HW1 (HW1)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (step),
    .col_in    ({px_bit, lb_rd}),
    .orow      (orow_r),
    .ocol      (ocol_r),
    .width     (w_eff),
    .height    (h_eff),
    .operation (op_r),
    .hit       (hit)
  );

  bmo_div #(
    .NUM_W (NW),
    .DEN_W (WW1),
    .CNT_W (DCNTW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_pend_r),
    .num   (out_cnt_r),
    .den   (w_eff),
    .quo   (div_quo),
    .rem   (div_rem),
    .busy  (div_busy),
    .done  (div_done)
  );

endmodule
`default_nettype wire

// ===== tb/octagon_morph_checker.sv =====
`timescale 1ns / 100ps
module octagon_morph_checker #(
  parameter int MAX_W = bmo_pkg::DEF_MAX_WIDTH,
  parameter int MAX_H = bmo_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // in_tdata: [7:0] gray_level
  input  logic [bmo_pkg::PIX_W-1:0]      in_tdata,
  // in_tuser: [0] drain
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: [7:0] out_pixel
  input  logic [bmo_pkg::PIX_W-1:0]      out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [bmo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             waiting,
  output int                             results_seen,
  output int                             frames_seen,
  output logic                           frame_open
);
  import bmo_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } px_due_t;

  px_due_t                 pixel_due[$];
  px_due_t                 head;
  bit                      line_mem [LINES][MAX_W];
  logic [WIN_N*WIN_N-1:0]  win;
  int unsigned             col_pos;
  int unsigned             row_pos;
  int unsigned             done_px;
  logic                    op_sel;
  logic [PIX_W-1:0]        thr;
  logic [CFG_DATA_W-1:0]   width_raw;
  logic [CFG_DATA_W-1:0]   height_raw;

  function automatic int unsigned clip_size(input logic [CFG_DATA_W-1:0] raw,
                                            input int unsigned top_lim);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > top_lim) return top_lim;
    return raw;
  endfunction

  task automatic octagon_step(input logic [PIX_W-1:0] gray, input logic drain);
    int unsigned w, h, total, col, lag, pos, orow, ocol;
    int yy, xx;
    logic [LINES:0] fresh;
    logic bin, any_set, all_set, b;
    px_due_t due;
    w = clip_size(width_raw, MAX_W);
    h = clip_size(height_raw, MAX_H);
    total = w * h;
    // drop drain transfers while image pixels are still due
    if (row_pos < h && drain) return;
    bin = (row_pos < h) && (gray >= thr);
    col = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
    for (int k = 0; k < LINES; k++) fresh[k] = line_mem[k][col];
    fresh[LINES] = bin;
    for (int r = 0; r < WIN_N; r++)
      win[r*WIN_N +: WIN_N] = {win[r*WIN_N +: WIN_N-1], fresh[r]};
    for (int k = 0; k < LINES; k++) line_mem[k][col] = fresh[k+1];
    lag = 2 * w + 2;
    pos = row_pos * w + col_pos;
    if (pos >= lag && done_px < total) begin
      orow = done_px / w;
      ocol = done_px % w;
      any_set = 1'b0;
      all_set = 1'b1;
      for (int dr = -KERN_HALF; dr <= KERN_HALF; dr++) begin
        for (int dc = -KERN_HALF; dc <= KERN_HALF; dc++) begin
          if (dr * dr == KERN_HALF * KERN_HALF && dc * dc == KERN_HALF * KERN_HALF) continue;
          yy = int'(orow) + dr;
          xx = int'(ocol) + dc;
          b = 1'b0;
          if (yy >= 0 && yy < int'(h) && xx >= 0 && xx < int'(w))
            b = win[(dr + KERN_HALF) * WIN_N + (KERN_HALF - dc)];
          any_set = any_set | b;
          all_set = all_set & b;
        end
      end
      due.pixel = ((op_sel == OP_ERODE) ? all_set : any_set) ? PIX_SET : PIX_CLEAR;
      due.last = (done_px == total - 1);
      pixel_due.push_back(due);
      done_px++;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    if (done_px >= total) begin
      col_pos = 0;
      row_pos = 0;
      done_px = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      op_sel = OP_DILATE;
      thr = THRESHOLD_RST;
      width_raw = FRAME_SIZE_RST;
      height_raw = FRAME_SIZE_RST;
      foreach (line_mem[k, c]) line_mem[k][c] = 1'b0;
      win = '0;
      col_pos = 0;
      row_pos = 0;
      done_px = 0;
      pixel_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_OPERATION:    op_sel = cfg_wdata[0];
          REG_THRESHOLD:    thr = cfg_wdata[PIX_W-1:0];
          REG_FRAME_WIDTH:  width_raw = cfg_wdata;
          REG_FRAME_HEIGHT: height_raw = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) octagon_step(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tlast) frames_seen++;
        if (pixel_due.size() == 0) begin
          $error("out transfer with nothing expected: out_pixel %0d last_of_frame %0b",
                 out_tdata, out_tlast);
          mismatches++;
        end else begin
          head = pixel_due.pop_front();
          if (out_tdata !== head.pixel) begin
            $error("out_pixel: expected %0d, actual %0d", head.pixel, out_tdata);
            mismatches++;
          end
          if (out_tlast !== head.last) begin
            $error("last_of_frame: expected %0b, actual %0b", head.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    waiting = pixel_due.size();
    frame_open = (row_pos != 0) || (col_pos != 0) || (done_px != 0);
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import bmo_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES   = 64;
  localparam int RANDOM_ITEMS  = 1350;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int   mismatches;
  int   waiting;
  int   results_seen;
  int   frames_seen;
  logic frame_open;

  int               items_sent = 0;
  int               burst_left = 0;
  int               hold_asks = 0;
  int               hold_done = 0;
  int               quiet_cycles = 0;
  logic [PIX_W-1:0] cur_thr;
  int unsigned      cur_w;
  int unsigned      cur_h;

  logic [PIX_W-1:0] demo_px [25] = '{
    8'd0,   8'd128, 8'd255, 8'd200, 8'd127,
    8'd129, 8'd255, 8'd254, 8'd192, 8'd160,
    8'd130, 8'd255, 8'd128, 8'd250, 8'd140,
    8'd255, 8'd131, 8'd170, 8'd255, 8'd128,
    8'd1,   8'd240, 8'd128, 8'd199, 8'd100
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_morphology_octagon_stream_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  octagon_morph_checker morph_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .results_seen (results_seen),
    .frames_seen  (frames_seen),
    .frame_open   (frame_open)
  );

  function automatic int unsigned size_used(input int unsigned raw, input int unsigned top_lim);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > top_lim) return top_lim;
    return raw;
  endfunction

  function automatic logic [PIX_W-1:0] gray_pick(input int unsigned density);
    if ($urandom_range(0, 99) < density) return PIX_W'($urandom_range(int'(cur_thr), 255));
    if (cur_thr == 8'd0) return PIX_W'($urandom_range(0, 255));
    return PIX_W'($urandom_range(0, int'(cur_thr) - 1));
  endfunction

  task automatic offer(input logic [PIX_W-1:0] gray, input logic drain);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= gray;
    in_tuser <= drain;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD:    cur_thr = PIX_W'(val);
      REG_FRAME_WIDTH:  cur_w = size_used(val, DEF_MAX_WIDTH);
      REG_FRAME_HEIGHT: cur_h = size_used(val, DEF_MAX_HEIGHT);
      default: ;
    endcase
  endtask

  task automatic send_frame(input int unsigned density);
    for (int unsigned n = 0; n < cur_w * cur_h; n++) begin
      // ignored drain in the image part
      if ($urandom_range(0, 24) == 0) offer(PIX_W'($urandom), 1'b1);
      offer(gray_pick(density), 1'b0);
      items_sent++;
    end
    for (int unsigned n = 0; n < 2 * cur_w + 2; n++) begin
      offer(PIX_W'($urandom), $urandom_range(0, 4) != 0);
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned density;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_OPERATION;
    cfg_wdata = '0;
    rst_n = 1'b0;
    cur_thr = THRESHOLD_RST;
    cur_w = FRAME_SIZE_RST;
    cur_h = FRAME_SIZE_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the line store clear is done
    do @(negedge clk); while (!in_tready);

    write_reg(REG_OPERATION, OP_DILATE);
    write_reg(REG_THRESHOLD, THRESHOLD_RST);
    write_reg(REG_FRAME_WIDTH, MIN_SIZE);
    write_reg(REG_FRAME_HEIGHT, MIN_SIZE);
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        settle();
        write_reg(REG_OPERATION, OP_ERODE);
      end
      for (int n = 0; n < 25; n++) begin
        if (n == 12) offer(PIX_SET, 1'b1);
        offer(demo_px[n], 1'b0);
        items_sent++;
      end
      for (int n = 0; n < 12; n++) begin
        if (n == 3 || n == 7) offer((n == 3) ? PIX_SET : PIX_CLEAR, 1'b0);
        else offer(8'h5A, 1'b1);
        items_sent++;
      end
    end

    // stall the receiver long enough to back up the input
    settle();
    write_reg(REG_OPERATION, OP_DILATE);
    write_reg(REG_FRAME_WIDTH, 12);
    write_reg(REG_FRAME_HEIGHT, 9);
    hold_asks++;
    send_frame(50);

    while (items_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 1)) write_reg(REG_OPERATION, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: write_reg(REG_THRESHOLD, 0);
        1: write_reg(REG_THRESHOLD, 255);
        2, 3: write_reg(REG_THRESHOLD, $urandom_range(0, 255));
        default: ;
      endcase
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_FRAME_WIDTH,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12));
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_FRAME_HEIGHT,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9));
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0: density = 15;
          1: density = 50;
          2: density = 85;
          default: density = 97;
        endcase
        send_frame(density);
      end
    end

    // resize in the middle of a frame
    settle();
    write_reg(REG_OPERATION, $urandom_range(0, 1));
    write_reg(REG_THRESHOLD, THRESHOLD_RST);
    write_reg(REG_FRAME_WIDTH, 8);
    write_reg(REG_FRAME_HEIGHT, 8);
    for (int n = 0; n < 30; n++) begin
      offer(gray_pick(70), 1'b0);
      items_sent++;
    end
    settle();
    write_reg(REG_FRAME_WIDTH, 6);
    write_reg(REG_FRAME_HEIGHT, 7);
    do begin
      offer(gray_pick(70), 1'b0);
      items_sent++;
      @(negedge clk);
      in_tvalid <= 1'b0;
    end while (frame_open);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Streamed %0d pixel and flush transfers, checked %0d result pixels over %0d frames,",
             items_sent, results_seen, frames_seen);
    $display("both dilation and erosion, thresholds 0 to 255, frame sides 5 to 12 and clipped.");
    if (mismatches == 0 && waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned mode, span, tick;
    mode = 0;
    span = 0;
    tick = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_asks) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 250);
        end
        span--;
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= (tick % 5 != 0);
          default: out_tready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
